// ===== src/dhtr_pkg.sv =====
`default_nettype none
package dhtr_pkg;
    localparam int LEAF_SIZE_DEF = 16;
    localparam int TABLE_ROWS = 8;
    localparam int TABLE_COLS = 16;
    localparam int TABLE_SIZE = TABLE_ROWS * TABLE_COLS;
    localparam int NEIGHBOR_SIZE_DEF = 32;
    localparam logic [31:0] EMPTY_ENTRY = 32'hFFFF_FFFF;
    localparam logic [2:0] MAX_PREFIX = 3'd7;

    localparam logic [1:0] OP_ROUTE = 2'd0;
    localparam logic [1:0] OP_LEAF = 2'd1;
    localparam logic [1:0] OP_TABLE = 2'd2;
    localparam logic [1:0] OP_NEIGHBOR = 2'd3;

    localparam logic [1:0] CLS_ARRIVED = 2'd0;
    localparam logic [1:0] CLS_LEAF = 2'd1;
    localparam logic [1:0] CLS_TABLE = 2'd2;
    localparam logic [1:0] CLS_FALLBACK = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [6:0]  slot;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_id;
        logic [1:0]  route_class;
    } t_out_item;

    function automatic logic [31:0] abs_gap(input logic [31:0] a, input logic [31:0] b);
        abs_gap = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [2:0] shared_prefix(input logic [31:0] a,
                                                 input logic [31:0] b);
        logic [2:0] n;
        logic       stop;
        n = 3'd0;
        stop = 1'b0;
        for (int k = 0; k < int'(MAX_PREFIX); k++) begin
            if (!stop && a[31-4*k -: 4] == b[31-4*k -: 4]) begin
                n = n + 3'd1;
            end else begin
                stop = 1'b1;
            end
        end
        shared_prefix = n;
    endfunction
endpackage
`default_nettype wire

// ===== src/dhtr_cand_unit.sv =====
`default_nettype none
module dhtr_cand_unit (
    input  wire logic [31:0] i_cand,
    input  wire logic [31:0] i_key,
    input  wire logic [2:0]  i_row,
    input  wire logic        i_need_prefix,
    input  wire logic [31:0] i_best_d,
    output logic             o_take,
    output logic [31:0]      o_d
);
    always_comb begin
        o_d = dhtr_pkg::abs_gap(i_key, i_cand);
        o_take = (i_cand != dhtr_pkg::EMPTY_ENTRY) && (o_d < i_best_d) &&
                 (!i_need_prefix || (dhtr_pkg::shared_prefix(i_key, i_cand) >= i_row));
    end
endmodule
`default_nettype wire

// ===== src/dht_prefix_route_next_hop_core.sv =====
`default_nettype none
// A route item reads one stored entry per cycle, and its candidates pass through a
// single distance compare unit: it scans the leaf set to find the leaf range, tests
// it, scans the leaf set again on a leaf set hit, or else makes a table lookup, and
// on a table miss makes a fallback scan over the leaf set, table and neighbour set.
// After reset a clearing pass empties the routing table before the first item is
// taken; the leaf and neighbour sets are emptied by reset itself. Results wait in
// an output register, and no new item is taken while a result waits.
module dht_prefix_route_next_hop_core #(
    parameter int LEAF_SIZE = dhtr_pkg::LEAF_SIZE_DEF,
    parameter int NEIGHBOR_SIZE = dhtr_pkg::NEIGHBOR_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire dhtr_pkg::t_in_item i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output dhtr_pkg::t_out_item     o_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [31:0]        i_cfg_data
);
    localparam int TS = dhtr_pkg::TABLE_SIZE;
    localparam int LW = $clog2(LEAF_SIZE);
    localparam int NW = $clog2(NEIGHBOR_SIZE);

    localparam logic [3:0] S_CLR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RANGE = 4'd2;
    localparam logic [3:0] S_LEAF = 4'd3;
    localparam logic [3:0] S_TAB = 4'd4;
    localparam logic [3:0] S_TAB2 = 4'd5;
    localparam logic [3:0] S_FL = 4'd6;
    localparam logic [3:0] S_FT = 4'd7;
    localparam logic [3:0] S_FN = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;
    localparam logic [3:0] S_WR = 4'd10;

    logic [31:0] r_leaf [LEAF_SIZE];
    logic [31:0] r_nbr [NEIGHBOR_SIZE];
    logic [31:0] r_tab [TS];
    logic [31:0] r_tab_q;

    logic [3:0]  r_state;
    logic [7:0]  r_idx;
    logic [31:0] r_own, r_key, r_best, r_best_d, r_lo, r_hi;
    logic [2:0]  r_row;
    logic        r_any;
    dhtr_pkg::t_in_item r_in;
    logic [6:0]  r_tab_addr;
    logic        r_tab_we;
    logic [31:0] r_tab_wd;

    logic [31:0] cand, cand_d;
    logic        take, need_pfx;
    logic [6:0]  tab_ra;

    assign o_ready = (r_state == S_IDLE) && !o_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (r_tab_we) begin
            r_tab[r_tab_addr] <= r_tab_wd;
        end
        r_tab_q <= r_tab[tab_ra];
    end

    always_comb begin
        tab_ra = r_idx[6:0];
        if (r_state == S_IDLE) begin
            tab_ra = 7'd0;
        end else if (r_state == S_RANGE || r_state == S_TAB || r_state == S_LEAF) begin
            tab_ra = {r_row, r_key[31 - 4*r_row -: 4]};
        end
    end

    always_comb begin
        cand = r_tab_q;
        need_pfx = (r_state != S_LEAF);
        if (r_state == S_LEAF || r_state == S_FL) begin
            cand = r_leaf[r_idx[LW-1:0]];
        end else if (r_state == S_FN) begin
            cand = r_nbr[r_idx[NW-1:0]];
        end
    end

    dhtr_cand_unit u_cand (
        .i_cand(cand), .i_key(r_key), .i_row(r_row), .i_need_prefix(need_pfx),
        .i_best_d(r_best_d), .o_take(take), .o_d(cand_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx <= '0;
            r_own <= '0;
            o_valid <= 1'b0;
            r_tab_we <= 1'b0;
            for (int k = 0; k < LEAF_SIZE; k++) r_leaf[k] <= dhtr_pkg::EMPTY_ENTRY;
            for (int k = 0; k < NEIGHBOR_SIZE; k++) r_nbr[k] <= dhtr_pkg::EMPTY_ENTRY;
        end else begin
            r_tab_we <= (r_state == S_CLR) ||
                        (r_state == S_WR && r_in.op == dhtr_pkg::OP_TABLE);
            if (i_cfg_valid) begin
                r_own <= i_cfg_data;
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end else if (r_state == S_OUT) begin
                o_valid <= 1'b1;
            end
            unique case (r_state)
                S_CLR: begin
                    r_tab_addr <= r_idx[6:0];
                    r_tab_wd <= dhtr_pkg::EMPTY_ENTRY;
                    r_idx <= r_idx + 8'd1;
                    if (r_idx == 8'(TS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in <= i_data;
                        r_key <= i_data.key;
                        r_best <= r_own;
                        r_best_d <= dhtr_pkg::abs_gap(i_data.key, r_own);
                        r_row <= dhtr_pkg::shared_prefix(i_data.key, r_own);
                        r_idx <= '0;
                        r_any <= 1'b0;
                        if (i_data.op != dhtr_pkg::OP_ROUTE) begin
                            r_state <= S_WR;
                        end else if (i_data.key == r_own) begin
                            o_data.next_id <= i_data.key;
                            o_data.route_class <= dhtr_pkg::CLS_ARRIVED;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RANGE;
                        end
                    end
                end
                S_WR: begin
                    unique case (r_in.op)
                        dhtr_pkg::OP_LEAF: begin
                            if (32'(r_in.slot) < LEAF_SIZE)
                                r_leaf[r_in.slot[LW-1:0]] <= r_in.key;
                        end
                        dhtr_pkg::OP_NEIGHBOR: begin
                            if (32'(r_in.slot) < NEIGHBOR_SIZE)
                                r_nbr[r_in.slot[NW-1:0]] <= r_in.key;
                        end
                        default: begin
                            r_tab_addr <= r_in.slot;
                            r_tab_wd <= r_in.key;
                        end
                    endcase
                    r_state <= S_IDLE;
                end
                S_RANGE: begin
                    if (r_leaf[r_idx[LW-1:0]] != dhtr_pkg::EMPTY_ENTRY) begin
                        if (!r_any) r_lo <= r_leaf[r_idx[LW-1:0]];
                        r_hi <= r_leaf[r_idx[LW-1:0]];
                        r_any <= 1'b1;
                    end
                    if (r_idx == 8'(LEAF_SIZE - 1)) begin
                        r_idx <= '0;
                        r_state <= S_TAB;
                    end else begin
                        r_idx <= r_idx + 8'd1;
                    end
                end
                S_TAB: begin
                    if (r_any && r_key >= r_lo && r_key <= r_hi) begin
                        r_state <= S_LEAF;
                    end else begin
                        r_state <= S_TAB2;
                    end
                end
                S_LEAF: begin
                    if (take) begin
                        r_best <= cand;
                        r_best_d <= cand_d;
                    end
                    r_idx <= r_idx + 8'd1;
                    if (r_idx == 8'(LEAF_SIZE - 1)) begin
                        o_data.next_id <= take ? cand : r_best;
                        o_data.route_class <= dhtr_pkg::CLS_LEAF;
                        r_state <= S_OUT;
                    end
                end
                S_TAB2: begin
                    if (r_tab_q != dhtr_pkg::EMPTY_ENTRY) begin
                        o_data.next_id <= r_tab_q;
                        o_data.route_class <= dhtr_pkg::CLS_TABLE;
                        r_state <= S_OUT;
                    end else begin
                        r_idx <= '0;
                        r_state <= S_FL;
                    end
                end
                S_FL: begin
                    if (take) begin
                        r_best <= cand;
                        r_best_d <= cand_d;
                    end
                    if (r_idx == 8'(LEAF_SIZE - 1)) begin
                        r_idx <= 8'd0;
                        r_state <= S_FT;
                    end else begin
                        r_idx <= r_idx + 8'd1;
                    end
                end
                S_FT: begin
                    // Memory data is registered and arrives in the cycle after its address.
                    if (r_idx != 8'd0 && take) begin
                        r_best <= cand;
                        r_best_d <= cand_d;
                    end
                    if (r_idx == 8'(TS)) begin
                        r_idx <= '0;
                        r_state <= S_FN;
                    end else begin
                        r_idx <= r_idx + 8'd1;
                    end
                end
                S_FN: begin
                    if (take) begin
                        r_best <= cand;
                        r_best_d <= cand_d;
                    end
                    r_idx <= r_idx + 8'd1;
                    if (r_idx == 8'(NEIGHBOR_SIZE - 1)) begin
                        o_data.next_id <= take ? cand : r_best;
                        o_data.route_class <= dhtr_pkg::CLS_FALLBACK;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/dhtr_checker.sv =====
`default_nettype none
module dhtr_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire dhtr_pkg::t_out_item o_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result item changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input accepted while a result waits");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after accepting an item");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind dht_prefix_route_next_hop_core dhtr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
`default_nettype wire
